// ===== hdl/pwdm_pkg.sv =====
`timescale 1ns / 1ps

package pwdm_pkg;

  // Fixed field widths of the transactions.
  localparam int PEN_W   = 7;
  localparam int CHAN_W  = 8;
  localparam int PROM_W  = 4;
  localparam int INDEX_W = 8;
  localparam int RGB_W   = 3 * CHAN_W;

  // Item kinds.
  localparam logic KIND_MAP  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Resistor weights of the four PROM bits; their sum is 8'hff.
  localparam logic [CHAN_W-1:0] WEIGHT_B0 = 8'h0e;
  localparam logic [CHAN_W-1:0] WEIGHT_B1 = 8'h1f;
  localparam logic [CHAN_W-1:0] WEIGHT_B2 = 8'h43;
  localparam logic [CHAN_W-1:0] WEIGHT_B3 = 8'h8f;

  // Converts a 4-bit PROM value into an 8-bit channel level.
  function automatic logic [CHAN_W-1:0] weigh(input logic [PROM_W-1:0] v);
    logic [CHAN_W-1:0] sum;
    sum = '0;
    if (v[0]) sum = sum + WEIGHT_B0;
    if (v[1]) sum = sum + WEIGHT_B1;
    if (v[2]) sum = sum + WEIGHT_B2;
    if (v[3]) sum = sum + WEIGHT_B3;
    return sum;
  endfunction

endpackage

// ===== hdl/palette_weight_dedup_map_top.sv =====
// Palette deduplication map. A map transaction carries a color as three 4-bit PROM values;
// each channel is weighted by fixed resistor weights into 8 bits, the color table is
// scanned from entry 0 upward for an equal triple, and the matching pen is returned. A new
// color is appended as the next pen and returned with is_new set; when the table already
// holds PALETTE_ENTRIES colors, pen 0 is returned with table_full set and the table stays
// unchanged. A read transaction returns the stored color at entry_index, or zeros when the
// index is at or beyond the current number of entries; pen, is_new and table_full are zero
// for reads. The table lives in one single-port-write RAM with a registered read, so the scan
// compares one entry per cycle. One transaction is worked on at a time; a finished result sits
// in the output register, so the next input transaction is accepted while it waits to be
// taken. Pens are 7 bits wide, so at sizes above 128 entries the pen wraps.
`timescale 1ns / 1ps

module palette_weight_dedup_map_top
  import pwdm_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [PROM_W-1:0]  prom_red,
  input  logic [PROM_W-1:0]  prom_green,
  input  logic [PROM_W-1:0]  prom_blue,
  input  logic [INDEX_W-1:0] entry_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PEN_W-1:0]   pen,
  output logic               is_new,
  output logic               table_full,
  output logic [CHAN_W-1:0]  red,
  output logic [CHAN_W-1:0]  green,
  output logic [CHAN_W-1:0]  blue
);

  // Index width of the table, and a count width that can hold a full table.
  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PALETTE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_t;

  state_t state;

  // Number of valid table entries.
  logic [CNT_W-1:0] count;
  // Entry whose data the RAM presents during the scan.
  logic [IDX_W-1:0] scan;

  // Color of the current map transaction, and the pending result.
  logic [RGB_W-1:0] cur_rgb;
  logic [PEN_W-1:0] res_pen;
  logic             res_new;
  logic             res_full;
  logic [RGB_W-1:0] res_rgb;

  logic [RGB_W-1:0] in_rgb;
  logic             in_accept;
  logic             out_free;
  logic             read_hit;
  logic             match;
  logic             scan_last;
  logic             table_is_full;
  logic             first_wr;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [RGB_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [RGB_W-1:0] rd_data;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign in_rgb = {weigh(prom_red), weigh(prom_green), weigh(prom_blue)};

  // A read hits only below the count, which never exceeds the table size.
  assign read_hit = (CMP_W'(entry_index) < CMP_W'(count));

  assign match         = (rd_data == cur_rgb);
  assign scan_last     = (CNT_W'(scan) + CNT_W'(1) == count);
  assign table_is_full = (count == FULL_COUNT);

  // A map into an empty table writes entry 0 directly in its accept cycle.
  assign first_wr = in_accept && (kind == KIND_MAP) && (count == '0);

  // A miss on the last valid entry appends the color unless the table is full.
  assign wr_en   = first_wr ||
                   ((state == S_SCAN) && !match && scan_last && !table_is_full);
  assign wr_addr = count[IDX_W-1:0];
  assign wr_data = first_wr ? in_rgb : cur_rgb;

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = (kind == KIND_READ) ? entry_index[IDX_W-1:0] : '0;
      S_SCAN:  rd_addr = scan + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  pwdm_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_color_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finish state loads a new result in the same cycle, so it owns out_valid there.
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            cur_rgb  <= in_rgb;
            scan     <= '0;
            res_pen  <= '0;
            res_new  <= 1'b0;
            res_full <= 1'b0;
            if (kind == KIND_READ) begin
              res_rgb <= '0;
              state   <= read_hit ? S_READ : S_FINISH;
            end else begin
              res_rgb <= in_rgb;
              if (count == '0) begin
                // Empty table: the color becomes pen 0 straight away.
                count   <= count + CNT_W'(1);
                res_new <= 1'b1;
                state   <= S_FINISH;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end

        S_SCAN: begin
          if (match) begin
            res_pen <= PEN_W'(scan);
            state   <= S_FINISH;
          end else if (scan_last) begin
            if (table_is_full) begin
              res_full <= 1'b1;
            end else begin
              res_pen <= PEN_W'(count);
              res_new <= 1'b1;
              count   <= count + CNT_W'(1);
            end
            state <= S_FINISH;
          end else begin
            scan <= scan + IDX_W'(1);
          end
        end

        S_READ: begin
          res_rgb <= rd_data;
          state   <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            pen        <= res_pen;
            is_new     <= res_new;
            table_full <= res_full;
            red        <= res_rgb[RGB_W-1 -: CHAN_W];
            green      <= res_rgb[CHAN_W +: CHAN_W];
            blue       <= res_rgb[0 +: CHAN_W];
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Assertions.

  // The entry count never exceeds the table size.
  assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("entry count beyond table size");

  // The scan never looks at an entry at or beyond the count.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNT_W'(scan) < count))
    else $error("scan index beyond entry count");

  // A delivered result is never both new and overflowed, and overflow uses pen 0.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && table_full) && (!table_full || (pen == '0)))
    else $error("inconsistent result flags");

  // The count changes only by one, alongside an append.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + CNT_W'(1)) && $past(res_new || wr_en || state == S_IDLE)))
    else $error("entry count changed without an append");

endmodule

// ===== hdl/pwdm_ram.sv =====
`timescale 1ns / 1ps

module pwdm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
